[sv/distinct_row_filter_unit_assert.svh]
//------------------------------------------------------------------------------
// distinct_row_filter_unit assertion macros
// Shared concurrent assertion shorthands, clocked on clock, off during reset.
//------------------------------------------------------------------------------
`ifndef DISTINCT_ROW_FILTER_UNIT_ASSERT_SVH
`define DISTINCT_ROW_FILTER_UNIT_ASSERT_SVH

// condition holds at every edge out of reset
`define DRF_ASSERT_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("distinct_row_filter_unit: check failed");

// same-cycle implication
`define DRF_ASSERT_IMPLY(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("distinct_row_filter_unit: check failed");

// next-cycle implication
`define DRF_ASSERT_NEXT(lbl, pre, post) \
   lbl: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("distinct_row_filter_unit: check failed");

`endif

[sv/drf_pkg.sv]
//------------------------------------------------------------------------------
// drf_pkg
// Shared types, sizes and the tuple compare for the distinct row filter.
//------------------------------------------------------------------------------
package drf_pkg;

   localparam int TABLE_DEPTH = 256;
   localparam int KEY_SLOTS   = 4;
   localparam int INPUT_SLOTS = 4;
   localparam int KEY_W       = 64;
   localparam int KC_W        = 3;
   localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam logic [KC_W-1:0] KEY_COUNT_RESET = KC_W'(4);

   typedef struct packed {
      logic [KEY_SLOTS-1:0]            nulls;
      logic [KEY_SLOTS-1:0][KEY_W-1:0] vals;
   } tuple_type;

   // one classified item: normalized tuple plus the slot count in force
   typedef struct packed {
      tuple_type       tuple;
      logic [KC_W-1:0] n;
   } work_type;

   // slot-wise match over the first n slots; nulls match nulls only
   function automatic logic tuple_match(tuple_type a, tuple_type b, logic [KC_W-1:0] n);
      logic m;
      m = 1'b1;
      for (int s = 0; s < KEY_SLOTS; s++) begin
         if (KC_W'(s) < n) begin
            if (a.nulls[s] != b.nulls[s]) begin
               m = 1'b0;
            end else if (!a.nulls[s] && (a.vals[s] != b.vals[s])) begin
               m = 1'b0;
            end
         end
      end
      return m;
   endfunction

endpackage

[sv/drf_front.sv]
//------------------------------------------------------------------------------
// drf_front
// Accepts items, zeroes null slots, clamps the slot count, queues two deep.
//------------------------------------------------------------------------------
module drf_front
   import drf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic signed [KEY_W-1:0] req_key_a,
   input  logic signed [KEY_W-1:0] req_key_b,
   input  logic signed [KEY_W-1:0] req_key_c,
   input  logic signed [KEY_W-1:0] req_key_d,
   input  logic [INPUT_SLOTS-1:0]  req_null_flags,
   input  logic [KC_W-1:0]         key_count,
   output logic                    q_valid,
   output work_type                q_item,
   input  logic                    q_pop
);

   localparam int QDEPTH = 2;

   work_type             slot_ff [QDEPTH];
   logic [1:0]           cnt_ff, cnt_in;
   logic                 wr_ptr_ff, wr_ptr_in;
   logic                 rd_ptr_ff, rd_ptr_in;
   work_type             item;
   logic [KEY_W-1:0]     in_keys [INPUT_SLOTS];
   logic                 push_ok, pop_ok;

   assign in_keys[0] = req_key_a;
   assign in_keys[1] = req_key_b;
   assign in_keys[2] = req_key_c;
   assign in_keys[3] = req_key_d;

   // normalize: null slot stored as zero, slots past the inputs read zero
   always_comb begin
      item.tuple = '0;
      for (int s = 0; s < KEY_SLOTS; s++) begin
         if (s < INPUT_SLOTS) begin
            item.tuple.nulls[s] = req_null_flags[s % INPUT_SLOTS];
            item.tuple.vals[s]  = req_null_flags[s % INPUT_SLOTS] ? '0
                                                                  : in_keys[s % INPUT_SLOTS];
         end
      end
      item.n = (key_count > KC_W'(KEY_SLOTS)) ? KC_W'(KEY_SLOTS) : key_count;
   end

   assign req_full = (cnt_ff == 2'(QDEPTH));
   assign q_valid  = (cnt_ff != 2'd0);
   assign q_item   = slot_ff[rd_ptr_ff];
   assign push_ok  = req_push && !req_full;
   assign pop_ok   = q_pop && q_valid;

   always_comb begin
      wr_ptr_in = push_ok ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop_ok ? !rd_ptr_ff : rd_ptr_ff;
      cnt_in    = cnt_ff + 2'(push_ok) - 2'(pop_ok);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
      end else begin
         cnt_ff    <= cnt_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_ok) begin
         slot_ff[wr_ptr_ff] <= item;
      end
   end

endmodule

[sv/drf_scan.sv]
//------------------------------------------------------------------------------
// drf_scan
// Seen-set table and scan engine: one stored tuple per cycle, then insert on a miss while room remains.
//------------------------------------------------------------------------------
`include "distinct_row_filter_unit_assert.svh"

module drf_scan
   import drf_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     q_valid,
   input  work_type q_item,
   output logic     q_pop,
   output logic     rsp_empty,
   input  logic     rsp_pop,
   output logic     rsp_keep,
   output logic     rsp_table_full
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_SCAN = 1'b1;

   tuple_type         mem [TABLE_DEPTH];
   tuple_type         rd_data_ff;
   logic              state_ff, state_in;
   work_type          cur_ff;
   logic [CNT_W-1:0]  addr_ff, addr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              rd_valid_ff, rd_valid_in;
   logic              out_valid_ff, out_valid_in;
   logic              out_keep_ff, out_full_ff;
   logic              hit, scan_done, out_free, finish, issue, store_en, take, at_full;

   assign at_full   = (count_ff == CNT_W'(TABLE_DEPTH));
   assign hit       = rd_valid_ff && tuple_match(cur_ff.tuple, rd_data_ff, cur_ff.n);
   assign scan_done = !rd_valid_ff && (addr_ff == count_ff);
   assign out_free  = !out_valid_ff || rsp_pop;
   assign take      = (state_ff == ST_IDLE) && q_valid;
   assign finish    = (state_ff == ST_SCAN) && (hit || scan_done) && out_free;
   assign issue     = (state_ff == ST_SCAN) && !hit && (addr_ff < count_ff);
   assign store_en  = finish && !hit && !at_full;
   assign q_pop     = take;

   always_comb begin
      state_in     = state_ff;
      addr_in      = addr_ff;
      rd_valid_in  = rd_valid_ff;
      count_in     = count_ff;
      out_valid_in = out_valid_ff && !rsp_pop;
      if (take) begin
         state_in    = ST_SCAN;
         addr_in     = '0;
         rd_valid_in = 1'b0;
      end else if (finish) begin
         state_in     = ST_IDLE;
         rd_valid_in  = 1'b0;
         out_valid_in = 1'b1;
         if (store_en) begin
            count_in = count_ff + 1'b1;
         end
      end else if ((state_ff == ST_SCAN) && !hit && !scan_done) begin
         // stream reads; the compare acts on the registered read, in the cycle after its address
         rd_valid_in = issue;
         if (issue) begin
            addr_in = addr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         addr_ff      <= '0;
         rd_valid_ff  <= 1'b0;
         count_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         addr_ff      <= addr_in;
         rd_valid_ff  <= rd_valid_in;
         count_ff     <= count_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         cur_ff <= q_item;
      end
      if (finish) begin
         out_keep_ff <= !hit;
         out_full_ff <= !hit && at_full;
      end
   end

   // table memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (store_en) begin
         mem[count_ff[ADDR_W-1:0]] <= cur_ff.tuple;
      end
      if (issue) begin
         rd_data_ff <= mem[addr_ff[ADDR_W-1:0]];
      end
   end

   assign rsp_empty      = !out_valid_ff;
   assign rsp_keep       = out_keep_ff;
   assign rsp_table_full = out_full_ff;

   `DRF_ASSERT_ALWAYS(a_count_bounded, count_ff <= CNT_W'(TABLE_DEPTH))
   `DRF_ASSERT_NEXT(a_store_bumps_count, store_en, count_ff == $past(count_ff) + 1'b1)
   `DRF_ASSERT_IMPLY(a_read_only_in_scan, rd_valid_ff, state_ff == ST_SCAN)
   `DRF_ASSERT_IMPLY(a_dup_never_full, out_valid_ff && !out_keep_ff, !out_full_ff)
   `DRF_ASSERT_IMPLY(a_scan_within_table, state_ff == ST_SCAN, addr_ff <= count_ff)

endmodule

[sv/distinct_row_filter_unit.sv]
//------------------------------------------------------------------------------
// distinct_row_filter_unit
// Streaming duplicate filter over a seen-set of up to four signed 64-bit keys.
//------------------------------------------------------------------------------
// Usage:
//  - Input queue: drive req_key_a..d and req_null_flags, raise req_push; the
//    item is taken on an edge with req_push high and req_full low.
//  - Result queue: while rsp_empty is low, rsp_keep / rsp_table_full show the
//    oldest result; it is taken on an edge with rsp_pop high.
//  - csr_wr_en/csr_wr_data write key_count (slots compared, clamped to 4).
//    Write it only while the block is idle.
// Scan: a new tuple is compared with every stored entry, a duplicate only
//  up to the entry where it is found; one stored tuple is read per cycle,
//  one item at a time.
// A two-deep input queue takes new items while a scan runs; a one-deep
//  result register holds the finished result. A result not popped holds
//  the scan engine at its last step, which then backs up the input queue.
// Reset: clears the entry count, both queues and sets key_count to 4. The
//  table needs no clearing: only entries below the count are read.
//------------------------------------------------------------------------------
module distinct_row_filter_unit
   import drf_pkg::*;
(
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_push,
   output logic                    req_full,
   input  logic signed [KEY_W-1:0] req_key_a,
   input  logic signed [KEY_W-1:0] req_key_b,
   input  logic signed [KEY_W-1:0] req_key_c,
   input  logic signed [KEY_W-1:0] req_key_d,
   input  logic [INPUT_SLOTS-1:0]  req_null_flags,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output logic                    rsp_keep,
   output logic                    rsp_table_full,
   input  logic                    csr_wr_en,
   input  logic [KC_W-1:0]         csr_wr_data
);

   logic [KC_W-1:0] key_count_ff;
   logic            q_valid;
   logic            q_pop;
   work_type        q_item;

   // key_count register, picked up by the front as each item is accepted
   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= KEY_COUNT_RESET;
      end else if (csr_wr_en) begin
         key_count_ff <= csr_wr_data;
      end
   end

   drf_front u_front (
      .clock          (clock),
      .reset          (reset),
      .req_push       (req_push),
      .req_full       (req_full),
      .req_key_a      (req_key_a),
      .req_key_b      (req_key_b),
      .req_key_c      (req_key_c),
      .req_key_d      (req_key_d),
      .req_null_flags (req_null_flags),
      .key_count      (key_count_ff),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop)
   );

   // back end: table scan, insert on first occurrence while room remains, result register
   drf_scan u_scan (
      .clock          (clock),
      .reset          (reset),
      .q_valid        (q_valid),
      .q_item         (q_item),
      .q_pop          (q_pop),
      .rsp_empty      (rsp_empty),
      .rsp_pop        (rsp_pop),
      .rsp_keep       (rsp_keep),
      .rsp_table_full (rsp_table_full)
   );

endmodule
